>>> sv/vertex_rotate_translate_top_defines.svh
`ifndef VERTEX_ROTATE_TRANSLATE_TOP_DEFINES_SVH
`define VERTEX_ROTATE_TRANSLATE_TOP_DEFINES_SVH

// same-cycle implication
`define VRT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define VRT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> sv/vrt_pkg.sv
package vrt_pkg;

	localparam int COORD_W = 32;
	localparam int ANG_W = 17;
	localparam int TRIG_W = 34;
	localparam int DISP_W = 36;
	localparam int ZACC_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TRIG_FRAC = 30;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIMB   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CX      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CY      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN    = 3'd6;

	typedef struct packed {
		logic                       busy;
		logic                       mode;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic signed [TRIG_W-1:0]   cos_v;
		logic signed [TRIG_W-1:0]   sin_v;
		logic signed [DISP_W-1:0]   dx;
		logic signed [DISP_W-1:0]   dy;
		logic signed [DISP_W-1:0]   dz;
	} xform_t;

	// atan(2^-i), hundredths of a degree times 2^16
	function automatic logic signed [ZACC_W-1:0] atan_val(input logic [4:0] idx);
		logic signed [ZACC_W-1:0] r;
		case (idx)
			5'd0: r = 32'sd294912000;
			5'd1: r = 32'sd174096719;
			5'd2: r = 32'sd91987925;
			5'd3: r = 32'sd46694507;
			5'd4: r = 32'sd23437865;
			5'd5: r = 32'sd11730358;
			5'd6: r = 32'sd5866610;
			5'd7: r = 32'sd2933484;
			5'd8: r = 32'sd1466764;
			5'd9: r = 32'sd733385;
			5'd10: r = 32'sd366693;
			5'd11: r = 32'sd183346;
			5'd12: r = 32'sd91673;
			5'd13: r = 32'sd45837;
			5'd14: r = 32'sd22918;
			5'd15: r = 32'sd11459;
			5'd16: r = 32'sd5730;
			5'd17: r = 32'sd2865;
			5'd18: r = 32'sd1432;
			5'd19: r = 32'sd716;
			5'd20: r = 32'sd358;
			5'd21: r = 32'sd179;
			5'd22: r = 32'sd90;
			5'd23: r = 32'sd45;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/vertex_rotate_translate_top.sv
// An accepted vertex passes through the s1, s2, s3 and s4 registers to out_valid.
// Throughput: one vertex per cycle while not busy, limited by out_ready.
// After reset, and after every register write, the iterative CORDIC and shared
// multiplier rebuild trig and displacement values, during which in_ready is low.
// Configuration registers reset to zero; cfg_ready is always high.
module vertex_rotate_translate_top #(
	parameter int CORDIC_STAGES = vrt_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [vrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vrt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [vrt_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [vrt_pkg::COORD_W-1:0] vertex_y,
	input  logic signed [vrt_pkg::COORD_W-1:0] vertex_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [vrt_pkg::COORD_W-1:0] out_x,
	output logic signed [vrt_pkg::COORD_W-1:0] out_y,
	output logic signed [vrt_pkg::COORD_W-1:0] out_z,
	output logic                               saturated
);
	import vrt_pkg::*;

	xform_t xf;

	assign cfg_ready = 1'b1;

	vrt_cfg #(.CORDIC_STAGES(CORDIC_STAGES)) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.xf(xf)
	);

	vrt_pipe u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.xf(xf),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.vertex_z(vertex_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.saturated(saturated)
	);

endmodule

>>> sv/vrt_cfg.sv
module vrt_cfg #(
	parameter int CORDIC_STAGES = vrt_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [vrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vrt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output vrt_pkg::xform_t                    xf
);
	import vrt_pkg::*;

	localparam int N_IT = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int IT_W = $clog2(N_IT);
	localparam int PROD_W = 2 * TRIG_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_ITER = 3'd2;
	localparam logic [2:0] ST_MULA = 3'd3;
	localparam logic [2:0] ST_MULB = 3'd4;
	localparam logic [2:0] ST_MULC = 3'd5;

	localparam logic [1:0] JOB_CLIMB = 2'd0;
	localparam logic [1:0] JOB_HEAD  = 2'd1;
	localparam logic [1:0] JOB_SPIN  = 2'd2;

	logic                      mode_q;
	logic signed [ANG_W-1:0]   heading_q, climb_q, spin_q;
	logic signed [COORD_W-1:0] dist_q, cx_q, cy_q;

	logic [2:0]                state_q;
	logic [1:0]                job_q;
	logic [IT_W-1:0]           it_q;
	logic                      neg_q;
	logic signed [TRIG_W-1:0]  x_q, y_q, h_q, cos_q, sin_q;
	logic signed [ZACC_W-1:0]  z_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [DISP_W-1:0]  dx_q, dy_q, dz_q;

	logic signed [ANG_W-1:0]   ang;
	logic signed [18:0]        a0, r1, r2, r3, r4, r5;
	logic                      fold;
	logic signed [TRIG_W-1:0]  sh_x, sh_y, cv, sv, a_op, t_op;
	logic signed [PROD_W-1:0]  rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			heading_q <= '0;
			climb_q <= '0;
			spin_q <= '0;
			dist_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:    mode_q <= cfg_data[0];
				REG_HEADING: heading_q <= cfg_data[ANG_W-1:0];
				REG_CLIMB:   climb_q <= cfg_data[ANG_W-1:0];
				REG_DIST:    dist_q <= cfg_data;
				REG_CX:      cx_q <= cfg_data;
				REG_CY:      cy_q <= cfg_data;
				REG_SPIN:    spin_q <= cfg_data[ANG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (job_q)
			JOB_CLIMB: ang = climb_q;
			JOB_HEAD:  ang = heading_q;
			default:   ang = spin_q;
		endcase
		a0 = 19'(ang) + 19'sd72000;
		r1 = (a0 >= 19'sd36000) ? a0 - 19'sd36000 : a0;
		r2 = (r1 >= 19'sd36000) ? r1 - 19'sd36000 : r1;
		r3 = (r2 >= 19'sd36000) ? r2 - 19'sd36000 : r2;
		r4 = (r3 > 19'sd18000) ? r3 - 19'sd36000 : r3;
		fold = (r4 > 19'sd9000) || (r4 < -19'sd9000);
		if (r4 > 19'sd9000)
			r5 = r4 - 19'sd18000;
		else if (r4 < -19'sd9000)
			r5 = r4 + 19'sd18000;
		else
			r5 = r4;
		sh_x = x_q >>> it_q;
		sh_y = y_q >>> it_q;
		cv = neg_q ? -x_q : x_q;
		sv = neg_q ? -y_q : y_q;
		a_op = (job_q == JOB_CLIMB) ? TRIG_W'(dist_q) : h_q;
		if (state_q == ST_MULA)
			t_op = (job_q == JOB_CLIMB) ? sv : cv;
		else
			t_op = (job_q == JOB_CLIMB) ? cv : sv;
		rnd = (prod_q + (PROD_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			job_q <= JOB_CLIMB;
		end else if (cfg_valid) begin
			state_q <= ST_LOAD;
			job_q <= JOB_CLIMB;
		end else begin
			case (state_q)
				ST_LOAD: state_q <= ST_ITER;
				ST_ITER: if (it_q == IT_W'(N_IT - 1)) state_q <= ST_MULA;
				ST_MULA: state_q <= (job_q == JOB_SPIN) ? ST_IDLE : ST_MULB;
				ST_MULB: state_q <= ST_MULC;
				ST_MULC: begin
					state_q <= ST_LOAD;
					job_q <= (job_q == JOB_CLIMB) ? JOB_HEAD : JOB_SPIN;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				z_q <= ZACC_W'(r5) <<< 16;
				neg_q <= fold;
				it_q <= '0;
			end
			ST_ITER: begin
				if (z_q >= 0) begin
					x_q <= x_q - sh_y;
					y_q <= y_q + sh_x;
					z_q <= z_q - atan_val(5'(it_q));
				end else begin
					x_q <= x_q + sh_y;
					y_q <= y_q - sh_x;
					z_q <= z_q + atan_val(5'(it_q));
				end
				it_q <= it_q + 1'b1;
			end
			ST_MULA: begin
				if (job_q == JOB_SPIN) begin
					cos_q <= cv;
					sin_q <= sv;
				end
				prod_q <= a_op * t_op;
			end
			ST_MULB: begin
				if (job_q == JOB_CLIMB)
					dz_q <= DISP_W'(rnd);
				else
					dx_q <= DISP_W'(rnd);
				prod_q <= a_op * t_op;
			end
			ST_MULC: begin
				if (job_q == JOB_CLIMB)
					h_q <= TRIG_W'(rnd);
				else
					dy_q <= DISP_W'(rnd);
			end
			default: ;
		endcase
	end

	assign xf.busy = (state_q != ST_IDLE);
	assign xf.mode = mode_q;
	assign xf.cx = cx_q;
	assign xf.cy = cy_q;
	assign xf.cos_v = cos_q;
	assign xf.sin_v = sin_q;
	assign xf.dx = dx_q;
	assign xf.dy = dy_q;
	assign xf.dz = dz_q;

endmodule

>>> sv/vrt_pipe.sv
`include "vertex_rotate_translate_top_defines.svh"

module vrt_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vrt_pkg::xform_t                   xf,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [vrt_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [vrt_pkg::COORD_W-1:0] vertex_y,
	input  logic signed [vrt_pkg::COORD_W-1:0] vertex_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [vrt_pkg::COORD_W-1:0] out_x,
	output logic signed [vrt_pkg::COORD_W-1:0] out_y,
	output logic signed [vrt_pkg::COORD_W-1:0] out_z,
	output logic                              saturated
);
	import vrt_pkg::*;

	localparam int DIF_W = COORD_W + 1;
	localparam int MUL_W = DIF_W + TRIG_W;
	localparam int SUM_W = 40;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [DIF_W-1:0]   px_s1, py_s1;
	logic signed [COORD_W-1:0] vx_s1, vy_s1, vz_s1;
	logic signed [MUL_W-1:0]   pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [COORD_W-1:0] vx_s2, vy_s2, vz_s2;
	logic signed [SUM_W-1:0]   sx_s3, sy_s3, sz_s3;
	logic signed [COORD_W-1:0] ox_s4, oy_s4, oz_s4;
	logic                      sat_s4;

	logic signed [SUM_W-1:0]   r_pxc, r_pys, r_pxs, r_pyc;
	logic [COORD_W:0]          sat_x, sat_y, sat_z;
	logic                      out_ext;

	function automatic logic signed [SUM_W-1:0] rnd(input logic signed [MUL_W-1:0] p);
		logic signed [MUL_W-1:0] t;
		t = (p + (MUL_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
		return SUM_W'(t);
	endfunction

	function automatic logic [COORD_W:0] sat(input logic signed [SUM_W-1:0] v);
		logic [COORD_W:0] r;
		if (v > SUM_W'(32'sh7fffffff))
			r = {1'b1, 32'h7fffffff};
		else if (v < -(SUM_W'(1) <<< (COORD_W - 1)))
			r = {1'b1, 32'h80000000};
		else
			r = {1'b0, v[COORD_W-1:0]};
		return r;
	endfunction

	assign en_s4 = !v_s4 || out_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1 && !xf.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid && in_ready;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		r_pxc = rnd(pxc_s2);
		r_pys = rnd(pys_s2);
		r_pxs = rnd(pxs_s2);
		r_pyc = rnd(pyc_s2);
		sat_x = sat(sx_s3);
		sat_y = sat(sy_s3);
		sat_z = sat(sz_s3);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1 <= DIF_W'(vertex_x) - DIF_W'(xf.cx);
			py_s1 <= DIF_W'(vertex_y) - DIF_W'(xf.cy);
			vx_s1 <= vertex_x;
			vy_s1 <= vertex_y;
			vz_s1 <= vertex_z;
		end
		if (en_s2) begin
			pxc_s2 <= px_s1 * xf.cos_v;
			pys_s2 <= py_s1 * xf.sin_v;
			pxs_s2 <= px_s1 * xf.sin_v;
			pyc_s2 <= py_s1 * xf.cos_v;
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			vz_s2 <= vz_s1;
		end
		if (en_s3) begin
			if (xf.mode) begin
				sx_s3 <= r_pxc - r_pys + SUM_W'(xf.cx);
				sy_s3 <= r_pxs + r_pyc + SUM_W'(xf.cy);
				sz_s3 <= SUM_W'(vz_s2);
			end else begin
				sx_s3 <= SUM_W'(vx_s2) + SUM_W'(xf.dx);
				sy_s3 <= SUM_W'(vy_s2) + SUM_W'(xf.dy);
				sz_s3 <= SUM_W'(vz_s2) + SUM_W'(xf.dz);
			end
		end
		if (en_s4) begin
			ox_s4 <= sat_x[COORD_W-1:0];
			oy_s4 <= sat_y[COORD_W-1:0];
			oz_s4 <= sat_z[COORD_W-1:0];
			sat_s4 <= sat_x[COORD_W] | sat_y[COORD_W] | sat_z[COORD_W];
		end
	end

	assign out_valid = v_s4;
	assign out_x = ox_s4;
	assign out_y = oy_s4;
	assign out_z = oz_s4;
	assign saturated = sat_s4;

	assign out_ext = (out_x == 32'sh7fffffff) || (out_x == 32'sh80000000) ||
		(out_y == 32'sh7fffffff) || (out_y == 32'sh80000000) ||
		(out_z == 32'sh7fffffff) || (out_z == 32'sh80000000);

	`VRT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, xf.busy, !(in_valid && in_ready))
	`VRT_ASSERT_NXT(a_s3_hold, clk, arst_n, v_s3 && !en_s3, v_s3)
	`VRT_ASSERT_NXT(a_s2_advance, clk, arst_n, v_s2 && en_s3, v_s3)
	`VRT_ASSERT_IMP(a_sat_extreme, clk, arst_n, out_valid && saturated, out_ext)

endmodule
